[hw/rtl/mlfq_pkg.sv]
`default_nettype none

package mlfq_pkg;

    localparam int LVL_W           = 3;
    localparam int REQ_W           = 2;
    localparam int PRIO_W          = 3;
    localparam int STATUS_W        = 2;
    localparam int ID_OUT_W        = 4;
    localparam int SLICE_W         = 6;
    localparam int SLICE_PER_LEVEL = 10;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_EXPIRE = 2'd1,
        REQ_EXIT   = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_IDLE    = 2'd2
    } t_status;

    // slot bitmap commands
    typedef struct packed {
        logic alloc;
        logic free;
    } t_slot_ctl;

    // ready queue commands; when both come in the same cycle, push is applied before pop
    typedef struct packed {
        logic             push;
        logic [LVL_W-1:0] push_lvl;
        logic             pop;
    } t_q_ctl;

    typedef struct packed {
        logic             any_ready;  // before this cycle's push
        logic             found;      // after this cycle's push
        logic [LVL_W-1:0] lvl;
    } t_q_sts;

endpackage

`default_nettype wire

[hw/rtl/mlfq_slot.sv]
`default_nettype none

module mlfq_slot #(
    parameter int MAX_THREADS = 16,
    parameter int ID_W        = $clog2(MAX_THREADS)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mlfq_pkg::t_slot_ctl  i_ctl,
    input  wire  [ID_W-1:0]      i_free_id,
    output logic                 o_found,
    output logic [ID_W-1:0]      o_id
);
    import mlfq_pkg::*;

    logic [MAX_THREADS-1:0] r_used;
    logic [MAX_THREADS-1:0] n_used;

    // lowest free slot
    always_comb begin
        o_found = 1'b0;
        o_id    = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                o_found = 1'b1;
                o_id    = ID_W'(i);
            end
        end
    end

    always_comb begin
        n_used = r_used;
        if (i_ctl.alloc) n_used[o_id] = 1'b1;
        if (i_ctl.free)  n_used[i_free_id] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

`ifndef SYNTHESIS
    a_alloc_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.alloc |-> o_found)
        else $error("slot allocated with none free");
    a_free_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.free |-> r_used[i_free_id])
        else $error("freeing a slot that is not in use");
    a_alloc_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.alloc && !i_ctl.free) |=> r_used[$past(o_id)])
        else $error("allocated slot not marked used");
`endif

endmodule

`default_nettype wire

[hw/rtl/mlfq_queues.sv]
`default_nettype none

// Ready queues kept as linked lists through a per-thread next pointer;
// a thread sits in at most one queue, so FIFO order is the list order.
module mlfq_queues #(
    parameter int MAX_THREADS = 16,
    parameter int NUM_LEVELS  = 6,
    parameter int ID_W        = $clog2(MAX_THREADS)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mlfq_pkg::t_q_ctl    i_ctl,
    input  wire  [ID_W-1:0]     i_push_id,
    output mlfq_pkg::t_q_sts    o_sts,
    output logic [ID_W-1:0]     o_pop_id
);
    import mlfq_pkg::*;

    localparam int LQ_W = $clog2(NUM_LEVELS);

    logic [NUM_LEVELS-1:0] r_valid;
    logic [ID_W-1:0]       r_head [NUM_LEVELS];
    logic [ID_W-1:0]       r_tail [NUM_LEVELS];
    logic [ID_W-1:0]       r_next [MAX_THREADS];

    logic [NUM_LEVELS-1:0] n_valid;
    logic [ID_W-1:0]       n_head [NUM_LEVELS];

    logic [LQ_W-1:0] push_idx;
    logic            v1 [NUM_LEVELS];
    logic [ID_W-1:0] h1 [NUM_LEVELS];
    logic [ID_W-1:0] t1 [NUM_LEVELS];
    logic [LQ_W-1:0] sel;
    logic            found;
    logic            pop_last;
    logic [ID_W-1:0] nxt;

    assign push_idx = i_ctl.push_lvl[LQ_W-1:0];

    // queue view after this cycle's push
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            v1[l] = r_valid[l];
            h1[l] = r_head[l];
            t1[l] = r_tail[l];
            if (i_ctl.push && push_idx == LQ_W'(l)) begin
                v1[l] = 1'b1;
                t1[l] = i_push_id;
                if (!r_valid[l]) h1[l] = i_push_id;
            end
        end
    end

    // lowest non-empty level
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (v1[l]) begin
                found = 1'b1;
                sel   = LQ_W'(l);
            end
        end
    end

    assign pop_last = (h1[sel] == t1[sel]);
    // next pointer of the old tail is being written this cycle
    assign nxt = (i_ctl.push && push_idx == sel && r_valid[sel] && h1[sel] == r_tail[sel])
               ? i_push_id : r_next[h1[sel]];

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            n_valid[l] = v1[l];
            n_head[l]  = h1[l];
        end
        if (i_ctl.pop && found) begin
            if (pop_last) n_valid[sel] = 1'b0;
            else          n_head[sel]  = nxt;
        end
    end

    assign o_pop_id        = h1[sel];
    assign o_sts.any_ready = |r_valid;
    assign o_sts.found     = found;
    assign o_sts.lvl       = LVL_W'(sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            r_head[l] <= n_head[l];
            r_tail[l] <= t1[l];
        end
        if (i_ctl.push && r_valid[push_idx]) r_next[r_tail[push_idx]] <= i_push_id;
    end

`ifndef SYNTHESIS
    a_pop_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> found)
        else $error("pop from empty queues");
    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> (i_ctl.push_lvl < LVL_W'(NUM_LEVELS)))
        else $error("push to level out of range");
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.pop) |=> r_valid[$past(push_idx)])
        else $error("pushed queue reads empty");
`endif

endmodule

`default_nettype wire

[hw/rtl/mlfq_thread_scheduler_top.sv]
// Multilevel feedback queue thread scheduler.
// Input stream (s_axis): one beat per request; tdata carries req_type and
// new_priority. Output stream (m_axis): exactly one result beat per request;
// tdata carries status, thread_id, parent_id, run_priority and time_slice.
// A request beat lands in an input register; slot allocation, queue update
// and dispatch are then all resolved in one pass and written to the
// output register, from which the result shows on m_axis. One request per
// cycle is sustained while m_axis_tready is high; the state read by a
// request is the state left by the one before it.
// A stalled output (m_axis_tready low) holds the result register and,
// once the input register is also full, drops s_axis_tready; no beat is
// lost or repeated. Synchronous active-low reset frees all slots, empties
// all ready queues and clears the running thread; the block is ready in
// the first cycle after reset.
`default_nettype none

module mlfq_thread_scheduler_top #(
    parameter int MAX_THREADS = 16,
    parameter int NUM_LEVELS  = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [1:0] req_type, [4:2] new_priority
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata    // [1:0] status, [5:2] thread_id,
                                        // [9:6] parent_id, [12:10] run_priority,
                                        // [18:13] time_slice
);
    import mlfq_pkg::*;

    localparam int ID_W = $clog2(MAX_THREADS);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(NUM_LEVELS - 1);

    logic                r_in_valid;
    logic [REQ_W-1:0]    r_req;
    logic [PRIO_W-1:0]   r_prio;
    logic                r_out_valid;
    logic [18:0]         r_out_data;
    logic                r_run_valid;
    logic [ID_W-1:0]     r_run_id;
    logic [LVL_W-1:0]    r_run_lvl;

    logic                n_run_valid;
    logic [ID_W-1:0]     n_run_id;
    logic [LVL_W-1:0]    n_run_lvl;

    logic                advance;
    t_slot_ctl           slot_raw, slot_ctl;
    t_q_ctl              q_raw, q_ctl;
    logic [ID_W-1:0]     push_id;
    logic                slot_found;
    logic [ID_W-1:0]     slot_id;
    t_q_sts              q_sts;
    logic [ID_W-1:0]     pop_id;
    logic                do_dispatch;
    logic [LVL_W-1:0]    clamp_lvl;
    logic [LVL_W-1:0]    demote_lvl;

    t_status             st;
    logic [ID_W-1:0]     res_id;
    logic [ID_W-1:0]     res_par;
    logic [LVL_W-1:0]    res_lvl;
    logic [ID_W+ID_OUT_W-1:0] id_ext, par_ext;
    logic [SLICE_W-1:0]  res_slice;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || advance);

    assign clamp_lvl  = (r_prio > LVL_MAX) ? LVL_MAX : r_prio;
    assign demote_lvl = (r_run_lvl >= LVL_MAX) ? LVL_MAX : r_run_lvl + LVL_W'(1);

    always_comb begin
        slot_raw    = '0;
        q_raw       = '0;
        push_id     = '0;
        do_dispatch = 1'b0;
        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_run_lvl   = r_run_lvl;
        st          = ST_IDLE;
        res_id      = '0;
        res_par     = '0;
        res_lvl     = '0;
        case (t_req'(r_req))
            REQ_CREATE: begin
                if (slot_found) begin
                    slot_raw.alloc = 1'b1;
                    q_raw.push     = 1'b1;
                    q_raw.push_lvl = clamp_lvl;
                    push_id        = slot_id;
                    st             = ST_OK;
                    res_id         = slot_id;
                    res_par        = r_run_valid ? r_run_id : '0;
                    res_lvl        = clamp_lvl;
                end else begin
                    st = ST_NO_SLOT;
                end
            end
            REQ_EXPIRE: begin
                if (r_run_valid && !q_sts.any_ready) begin
                    // nothing else ready: keep running, fresh slice
                    st      = ST_OK;
                    res_id  = r_run_id;
                    res_lvl = r_run_lvl;
                end else begin
                    if (r_run_valid) begin
                        q_raw.push     = 1'b1;
                        q_raw.push_lvl = demote_lvl;
                        push_id        = r_run_id;
                        n_run_valid    = 1'b0;
                    end
                    do_dispatch = 1'b1;
                end
            end
            REQ_EXIT: begin
                if (r_run_valid) begin
                    slot_raw.free = 1'b1;
                    n_run_valid   = 1'b0;
                end
                do_dispatch = 1'b1;
            end
            default: begin
                st = ST_IDLE;
            end
        endcase
        if (do_dispatch) begin
            if (q_sts.found) begin
                q_raw.pop   = 1'b1;
                st          = ST_OK;
                res_id      = pop_id;
                res_lvl     = q_sts.lvl;
                n_run_valid = 1'b1;
                n_run_id    = pop_id;
                n_run_lvl   = q_sts.lvl;
            end else begin
                st = ST_IDLE;
            end
        end
    end

    always_comb begin
        slot_ctl       = slot_raw;
        slot_ctl.alloc = slot_raw.alloc && advance;
        slot_ctl.free  = slot_raw.free && advance;
        q_ctl          = q_raw;
        q_ctl.push     = q_raw.push && advance;
        q_ctl.pop      = q_raw.pop && advance;
    end

    assign id_ext    = {{ID_OUT_W{1'b0}}, res_id};
    assign par_ext   = {{ID_OUT_W{1'b0}}, res_par};
    assign res_slice = SLICE_W'(SLICE_W'(res_lvl) * SLICE_W'(SLICE_PER_LEVEL));

    mlfq_slot #(
        .MAX_THREADS (MAX_THREADS)
    ) u_slot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (slot_ctl),
        .i_free_id (r_run_id),
        .o_found   (slot_found),
        .o_id      (slot_id)
    );

    mlfq_queues #(
        .MAX_THREADS (MAX_THREADS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_queues (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (q_ctl),
        .i_push_id (push_id),
        .o_sts     (q_sts),
        .o_pop_id  (pop_id)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_lvl   <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_run_valid <= n_run_valid;
                r_run_id    <= n_run_id;
                r_run_lvl   <= n_run_lvl;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req  <= s_axis_tdata[1:0];
            r_prio <= s_axis_tdata[4:2];
        end
        if (advance) begin
            r_out_data <= {res_slice, res_lvl, par_ext[ID_OUT_W-1:0],
                           id_ext[ID_OUT_W-1:0], st};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_data};

`ifndef SYNTHESIS
    a_dispatch_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ctl.pop |=> (r_run_valid && r_out_valid))
        else $error("dispatch did not leave a running thread");
    a_dispatch_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ctl.pop |=> (r_out_data[1:0] == ST_OK && r_run_id == $past(pop_id)))
        else $error("dispatched id mismatch");
    a_no_slot_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && st == ST_NO_SLOT) |-> (!q_ctl.push && !slot_ctl.alloc))
        else $error("state change on failed create");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import mlfq_pkg::*;

    localparam int MAX_THREADS = 16;
    localparam int NUM_LEVELS  = 6;
    localparam int RAND_ITEMS  = 876;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 4;

    // packed from the top down: slice, level, parent, id, status (lowest bits)
    typedef struct packed {
        logic [SLICE_W-1:0]  time_slice;
        logic [LVL_W-1:0]    run_prio;
        logic [ID_OUT_W-1:0] parent_id;
        logic [ID_OUT_W-1:0] thread_id;
        t_status             status;
    } t_sched_result;

    typedef struct {
        t_req                req;
        logic [PRIO_W-1:0]   prio;
        int unsigned         reps;
        bit                  typed;
        t_sched_result       res;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [1:0] req_type, [4:2] new_priority
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [1:0] status, [5:2] thread_id, [9:6] parent_id,
                                         // [12:10] run_priority, [18:13] time_slice

    always #2 i_clk = ~i_clk;

    mlfq_thread_scheduler_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // scheduler shadow state
    bit                  slot_busy [MAX_THREADS];
    logic [LVL_W-1:0]    thr_level [MAX_THREADS];
    logic [ID_OUT_W-1:0] rq_mem    [NUM_LEVELS][MAX_THREADS];
    int unsigned         rq_head   [NUM_LEVELS];
    int unsigned         rq_cnt    [NUM_LEVELS];
    logic [ID_OUT_W-1:0] run_id    = '0;
    bit                  run_valid = 1'b0;

    t_sched_result pending_results[$];
    int unsigned   err_count   = 0;
    int unsigned   tx_idle_pct = 26;
    int unsigned   rx_idle_pct = 72;
    bit            hold_armed  = 1'b0;
    bit            hold_done   = 1'b0;
    int unsigned   hold_left   = 0;
    int unsigned   stall_count = 0;

    // rows with a typed result are checked against it; the rest against the predictor
    // result fields listed as: slice, level, parent, id, status
    t_dir_row dir_rows[12] = '{
        '{REQ_EXPIRE, 3'd0, 1,  1'b1, '{6'd0,  3'd0, 4'd0, 4'd0, ST_IDLE}},
        '{REQ_EXIT,   3'd5, 1,  1'b1, '{6'd0,  3'd0, 4'd0, 4'd0, ST_IDLE}},
        '{REQ_CREATE, 3'd7, 1,  1'b1, '{6'd50, 3'd5, 4'd0, 4'd0, ST_OK}},
        '{REQ_EXPIRE, 3'd0, 1,  1'b1, '{6'd50, 3'd5, 4'd0, 4'd0, ST_OK}},
        // only thread, nothing ready: keeps running with a fresh slice
        '{REQ_EXPIRE, 3'd2, 1,  1'b1, '{6'd50, 3'd5, 4'd0, 4'd0, ST_OK}},
        '{REQ_CREATE, 3'd0, 1,  1'b0, '0},
        '{REQ_EXPIRE, 3'd1, 1,  1'b0, '0},
        '{REQ_CREATE, 3'd3, 1,  1'b0, '0},
        '{REQ_EXPIRE, 3'd4, 1,  1'b0, '0},
        '{REQ_EXIT,   3'd0, 1,  1'b0, '0},
        '{REQ_CREATE, 3'd6, 14, 1'b0, '0},
        // all sixteen slots taken
        '{REQ_CREATE, 3'd5, 1,  1'b1, '{6'd0,  3'd0, 4'd0, 4'd0, ST_NO_SLOT}}
    };

    function automatic t_sched_result make_result(t_status st, logic [ID_OUT_W-1:0] id,
                                                  logic [ID_OUT_W-1:0] pid,
                                                  logic [LVL_W-1:0] lvl);
        t_sched_result r;
        r.status     = st;
        r.thread_id  = id;
        r.parent_id  = pid;
        r.run_prio   = lvl;
        r.time_slice = SLICE_W'(lvl * SLICE_PER_LEVEL);
        return r;
    endfunction

    function automatic void push_ready(logic [LVL_W-1:0] lvl, logic [ID_OUT_W-1:0] id);
        if (rq_cnt[lvl] >= MAX_THREADS)
            return;
        rq_mem[lvl][(rq_head[lvl] + rq_cnt[lvl]) % MAX_THREADS] = id;
        rq_cnt[lvl]++;
    endfunction

    // pop the head of the highest-priority non-empty level
    function automatic t_sched_result dispatch_next();
        logic [ID_OUT_W-1:0] id;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (rq_cnt[l] != 0) begin
                id         = rq_mem[l][rq_head[l]];
                rq_head[l] = (rq_head[l] + 1) % MAX_THREADS;
                rq_cnt[l]--;
                run_id     = id;
                run_valid  = 1'b1;
                return make_result(ST_OK, id, '0, thr_level[id]);
            end
        end
        return make_result(ST_IDLE, '0, '0, '0);
    endfunction

    function automatic t_sched_result schedule_request(t_req req, logic [PRIO_W-1:0] prio);
        logic [LVL_W-1:0] lvl;
        bit               ready_any;
        case (req)
            REQ_CREATE: begin
                lvl = (prio > NUM_LEVELS - 1) ? LVL_W'(NUM_LEVELS - 1) : prio;
                for (int s = 0; s < MAX_THREADS; s++) begin
                    if (!slot_busy[s]) begin
                        slot_busy[s] = 1'b1;
                        thr_level[s] = lvl;
                        push_ready(lvl, ID_OUT_W'(s));
                        return make_result(ST_OK, ID_OUT_W'(s), run_valid ? run_id : '0, lvl);
                    end
                end
                return make_result(ST_NO_SLOT, '0, '0, '0);
            end
            REQ_EXPIRE: begin
                if (run_valid) begin
                    ready_any = 1'b0;
                    for (int l = 0; l < NUM_LEVELS; l++)
                        if (rq_cnt[l] != 0)
                            ready_any = 1'b1;
                    if (!ready_any)
                        return make_result(ST_OK, run_id, '0, thr_level[run_id]);
                    lvl = (thr_level[run_id] >= NUM_LEVELS - 1) ? LVL_W'(NUM_LEVELS - 1)
                                                                : thr_level[run_id] + 1'b1;
                    thr_level[run_id] = lvl;
                    run_valid = 1'b0;
                    push_ready(lvl, run_id);
                end
                return dispatch_next();
            end
            REQ_EXIT: begin
                if (run_valid) begin
                    slot_busy[run_id] = 1'b0;
                    run_valid = 1'b0;
                end
                return dispatch_next();
            end
            default: return make_result(ST_IDLE, '0, '0, '0);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        err_count++;
    endtask

    task automatic check_result(input t_sched_result got);
        t_sched_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending: %h", got));
            return;
        end
        want = pending_results[0];
        pending_results.delete(0);
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.thread_id !== want.thread_id)
            report_mismatch($sformatf("thread_id got %0d want %0d", got.thread_id,
                                      want.thread_id));
        if (got.parent_id !== want.parent_id)
            report_mismatch($sformatf("parent_id got %0d want %0d", got.parent_id,
                                      want.parent_id));
        if (got.run_prio !== want.run_prio)
            report_mismatch($sformatf("run_priority got %0d want %0d", got.run_prio,
                                      want.run_prio));
        if (got.time_slice !== want.time_slice)
            report_mismatch($sformatf("time_slice got %0d want %0d", got.time_slice,
                                      want.time_slice));
    endtask

    task automatic send_request(input t_req req, input logic [PRIO_W-1:0] prio,
                                input bit typed, input t_sched_result typed_res);
        t_sched_result pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, prio, req};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pred = schedule_request(req, prio);
        pending_results = {pending_results, (typed ? typed_res : pred)};
    endtask

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result(t_sched_result'(m_axis_tdata[$bits(t_sched_result)-1:0]));
        if (hold_armed && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // no beat on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_req        rq;
        int unsigned create_pct;
        int unsigned r;
        int unsigned phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            for (int n = 0; n < dir_rows[i].reps; n++)
                send_request(dir_rows[i].req, dir_rows[i].prio, dir_rows[i].typed,
                             dir_rows[i].res);

        for (int k = 0; k < RAND_ITEMS; k++) begin
            phase = k / (RAND_ITEMS / 3);
            if (phase == 1) begin
                tx_idle_pct  = 72;
                rx_idle_pct <= 26;
            end else if (phase >= 2) begin
                tx_idle_pct  = 0;
                rx_idle_pct <= 0;
                hold_armed  <= 1'b1;
            end
            // rotate between filling, mixed and draining stretches
            case ((k / 40) % 3)
                0:       create_pct = 60;
                1:       create_pct = 35;
                default: create_pct = 15;
            endcase
            r = $urandom_range(99);
            if (r < create_pct)
                rq = REQ_CREATE;
            else if (r < create_pct + (100 - create_pct) / 2)
                rq = REQ_EXPIRE;
            else
                rq = REQ_EXIT;
            send_request(rq, PRIO_W'($urandom_range(7)), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
